### hdl/lnt_pkg.sv
// Shared constants, types and helpers for the luma normalize and tint block.
`default_nettype none

package lnt_pkg;

    // Image store geometry
    localparam int MAX_PIXELS = 4096;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);

    // Field widths
    localparam int CHAN_W = 8;
    localparam int OP_W   = 2;
    localparam int CFG_W  = 2;

    // Opcodes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_W-1:0] CFG_TINT_RED   = 2'd0;
    localparam logic [CFG_W-1:0] CFG_TINT_GREEN = 2'd1;
    localparam logic [CFG_W-1:0] CFG_TINT_BLUE  = 2'd2;

    localparam logic [CHAN_W-1:0] TINT_RESET = 8'd255;

    // BT.601 luma weights in 0.16 fixed point
    localparam logic [23:0] LUMA_WR = 24'd19595;
    localparam logic [23:0] LUMA_WG = 24'd38470;
    localparam logic [23:0] LUMA_WB = 24'd7471;

    // Divider request and response
    typedef struct packed {
        logic                start;
        logic [15:0]         dividend;
        logic [CHAN_W-1:0]   divisor;
    } lnt_div_req_t;

    typedef struct packed {
        logic                done;
        logic [CHAN_W-1:0]   quotient;
    } lnt_div_resp_t;

    // Exact floor(p / 255) for p up to 255 * 255
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] p);
        logic [16:0] acc;
        acc = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
        return acc[15:8];
    endfunction

endpackage

`default_nettype wire

### hdl/lnt_div.sv
// Restoring divider: 8-bit quotient of a 16-bit dividend by an 8-bit divisor.
`default_nettype none

module lnt_div import lnt_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire lnt_div_req_t  req,
    output lnt_div_resp_t      resp
);

    logic [CHAN_W-1:0] rem_reg;
    logic [CHAN_W-1:0] quo_reg;
    logic [CHAN_W-1:0] divisor_reg;
    logic [2:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [CHAN_W:0]   trial;
    logic [CHAN_W:0]   diff;
    logic              ge;
    logic [CHAN_W-1:0] rem_next;
    logic [CHAN_W-1:0] quo_next;

    // One quotient bit per cycle; upper dividend byte is below the divisor
    always_comb begin
        trial    = {rem_reg, quo_reg[CHAN_W-1]};
        diff     = trial - {1'b0, divisor_reg};
        ge       = (trial >= {1'b0, divisor_reg});
        rem_next = ge ? diff[CHAN_W-1:0] : trial[CHAN_W-1:0];
        quo_next = {quo_reg[CHAN_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rem_reg     <= req.dividend[15:8];
                quo_reg     <= req.dividend[7:0];
                divisor_reg <= req.divisor;
                cnt_reg     <= '0;
                busy_reg    <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign resp.done     = done_reg;
    assign resp.quotient = quo_reg;

endmodule

`default_nettype wire

### hdl/luma_normalize_tint.sv
// Luma normalize and tint: top level with luma store, control and output register.
//
// Input channel (s_*): one transaction carries an opcode and its operands.
//   clear: empties the image. load: converts RGB to 8-bit luma and
//   appends it to the store; ignored once 4096 pixels are held.
//   read: returns the pixel at s_read_index normalized to the brightest
//   stored luma and scaled by the tint, with m_valid_res low (and black
//   color) for an index at or past the loaded count.
// A read goes from acceptance to the result register through the memory
// read at acceptance, the divider load, eight steps of the serial divider by
// the peak luma, one tint multiply and the result load. Only one transaction
// is in work at a time; s_ready is high while the control is idle.
// Result channel (m_*): a result register holds one transaction. The next
// input is accepted while a result waits; a read that finishes while the
// receiver still stalls holds in place until the register frees up.
// Configuration (cfg_*): tint_red, tint_green, tint_blue at indexes 0..2,
// always ready; write only while the block is idle.
// Reset: count and peak go to zero, tints to 255. The luma store is not
// cleared; only entries loaded since the last clear reach the output.
`default_nettype none

module luma_normalize_tint import lnt_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [OP_W-1:0]   s_opcode,
    input  wire logic [CHAN_W-1:0] s_pixel_red,
    input  wire logic [CHAN_W-1:0] s_pixel_green,
    input  wire logic [CHAN_W-1:0] s_pixel_blue,
    input  wire logic [ADDR_W-1:0] s_read_index,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [CHAN_W-1:0]      m_out_red,
    output logic [CHAN_W-1:0]      m_out_green,
    output logic [CHAN_W-1:0]      m_out_blue,
    output logic                   m_valid_res,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_index,
    input  wire logic [CHAN_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_READ,
        ST_DIV,
        ST_TINT
    } state_t;

    state_t            state_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [CHAN_W-1:0] peak_reg;
    logic [CHAN_W-1:0] tint_r_reg;
    logic [CHAN_W-1:0] tint_g_reg;
    logic [CHAN_W-1:0] tint_b_reg;

    logic [CHAN_W-1:0] luma_reg;
    logic              hit_reg;
    logic [15:0]       prod_r_reg;
    logic [15:0]       prod_g_reg;
    logic [15:0]       prod_b_reg;

    logic              m_valid_reg;
    logic [CHAN_W-1:0] out_r_reg;
    logic [CHAN_W-1:0] out_g_reg;
    logic [CHAN_W-1:0] out_b_reg;
    logic              out_vr_reg;

    logic [CHAN_W-1:0] luma_mem [MAX_PIXELS];
    logic [CHAN_W-1:0] rdata_reg;
    logic              mem_re;
    logic              mem_we;

    logic              s_fire;
    logic              out_free;
    logic [23:0]       luma_sum;
    logic [CHAN_W-1:0] n_val;

    lnt_div_req_t      div_req;
    lnt_div_resp_t     div_resp;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // Luma from RGB, 0.16 fixed point weights
    assign luma_sum = LUMA_WR * {16'd0, s_pixel_red}
                    + LUMA_WG * {16'd0, s_pixel_green}
                    + LUMA_WB * {16'd0, s_pixel_blue};

    // Luma store: one write port, one registered read port
    assign mem_re = s_fire && (s_opcode == OP_READ);
    assign mem_we = (state_reg == ST_LOAD);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            luma_mem[count_reg[ADDR_W-1:0]] <= luma_reg;
        end
        if (mem_re) begin
            rdata_reg <= luma_mem[s_read_index];
        end
    end

    // Divider gets luma * 255 over the peak
    assign div_req.start    = (state_reg == ST_READ);
    assign div_req.dividend = {rdata_reg, 8'd0} - {8'd0, rdata_reg};
    assign div_req.divisor  = peak_reg;

    lnt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .resp    (div_resp)
    );

    // Normalized level, black for a miss or a zero peak
    assign n_val = (hit_reg && (peak_reg != '0)) ? div_resp.quotient : '0;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tint_r_reg <= TINT_RESET;
            tint_g_reg <= TINT_RESET;
            tint_b_reg <= TINT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TINT_RED:   tint_r_reg <= cfg_data;
                CFG_TINT_GREEN: tint_g_reg <= cfg_data;
                CFG_TINT_BLUE:  tint_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control sequencer with image state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            peak_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        case (s_opcode)
                            OP_CLEAR: begin
                                count_reg <= '0;
                                peak_reg  <= '0;
                            end
                            OP_LOAD: begin
                                if (count_reg != CNT_W'(MAX_PIXELS)) begin
                                    luma_reg  <= luma_sum[23:16];
                                    state_reg <= ST_LOAD;
                                end
                            end
                            OP_READ: begin
                                hit_reg   <= ({1'b0, s_read_index} < count_reg);
                                state_reg <= ST_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_LOAD: begin
                    count_reg <= count_reg + CNT_W'(1);
                    if (luma_reg > peak_reg) begin
                        peak_reg <= luma_reg;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_READ: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_resp.done) begin
                        prod_r_reg <= {8'd0, n_val} * {8'd0, tint_r_reg};
                        prod_g_reg <= {8'd0, n_val} * {8'd0, tint_g_reg};
                        prod_b_reg <= {8'd0, n_val} * {8'd0, tint_b_reg};
                        state_reg  <= ST_TINT;
                    end
                end
                ST_TINT: begin
                    if (out_free) begin
                        out_r_reg   <= div255(prod_r_reg);
                        out_g_reg   <= div255(prod_g_reg);
                        out_b_reg   <= div255(prod_b_reg);
                        out_vr_reg  <= hit_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = out_r_reg;
    assign m_out_green = out_g_reg;
    assign m_out_blue  = out_b_reg;
    assign m_valid_res = out_vr_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_PIXELS))
        else $error("pixel count past capacity");

    a_empty_no_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (peak_reg == '0))
        else $error("peak luma set with empty image");

    a_miss_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_valid_res) |->
            (m_out_red == '0 && m_out_green == '0 && m_out_blue == '0))
        else $error("out-of-range read not black");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_opcode == OP_CLEAR) |=> (count_reg == '0 && peak_reg == '0))
        else $error("clear did not empty the image");

endmodule

`default_nettype wire
